// ===== rtl/bst_pkg.sv =====
// Shared types, constants and table lookups for the BASIC source tokenizer.
// Used by every module of the block but bst_ram; depends on nothing.
package bst_pkg;

    localparam int MAX_WORD_CHARS = 32;
    localparam int SHADOW_CHARS   = 6;
    localparam int WLEN_W         = $clog2(MAX_WORD_CHARS + 2);
    localparam int ADDR_W         = $clog2(MAX_WORD_CHARS);
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_NUMBER = 4'd1;
    localparam logic [3:0] KIND_STRING = 4'd2;
    localparam logic [3:0] KIND_KW     = 4'd3;
    localparam logic [3:0] KIND_FUNC   = 4'd4;
    localparam logic [3:0] KIND_OP     = 4'd5;
    localparam logic [3:0] KIND_EOI    = 4'd6;
    localparam logic [3:0] KIND_SEMI   = 4'd7;
    localparam logic [3:0] KIND_COMMA  = 4'd8;
    localparam logic [3:0] KIND_ERROR  = 4'd9;

    localparam logic [4:0] ERR_UNKNOWN = 5'd0;
    localparam logic [4:0] ERR_LONG    = 5'd1;
    localparam logic [4:0] ERR_STRING  = 5'd2;

    localparam logic [4:0] KW_END_IF = 5'd3;
    localparam logic [4:0] KW_END    = 5'd4;
    localparam logic [4:0] KW_IF     = 5'd8;

    localparam logic [4:0] OP_LPAREN = 5'd0;
    localparam logic [4:0] OP_RPAREN = 5'd1;
    localparam logic [4:0] OP_MUL    = 5'd2;
    localparam logic [4:0] OP_DIV    = 5'd3;
    localparam logic [4:0] OP_ADD    = 5'd5;
    localparam logic [4:0] OP_SUB    = 5'd6;
    localparam logic [4:0] OP_LT     = 5'd7;
    localparam logic [4:0] OP_LE     = 5'd8;
    localparam logic [4:0] OP_NE     = 5'd9;
    localparam logic [4:0] OP_GT     = 5'd10;
    localparam logic [4:0] OP_GE     = 5'd11;
    localparam logic [4:0] OP_EQ     = 5'd12;
    localparam logic [4:0] CODE_NONE = 5'd0;

    typedef enum logic [3:0] {
        CLS_LETTER, CLS_DIGIT, CLS_SPACE, CLS_QUOTE, CLS_NEWLINE,
        CLS_SEMI, CLS_COMMA, CLS_OP, CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_NUM, MODE_STR} t_mode;
    typedef enum logic [1:0] {PEND_NONE, PEND_END, PEND_LT, PEND_GT} t_pend;

    typedef enum logic [2:0] {
        WK_NONE, WK_MERGE, WK_END, WK_KW, WK_FN, WK_OP, WK_IDENT
    } t_wk;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_WF, S_WF_FLUSH, S_WF_TOK, S_IRD, S_IEM,
        S_NUM_END, S_STR_END, S_STR_ERR, S_CHAR, S_CHAR_FLUSH, S_CHAR_TOK,
        S_OVF_FLUSH, S_OVF_ERR, S_EOS_FLUSH, S_EOS_EOI, S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
        logic [4:0] opc;
        logic       eos;
    } t_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] code;
        logic [7:0] ch;
        logic       cv;
        logic       first;
        logic       last;
    } t_item;

    typedef struct packed {
        t_wk        wk;
        logic [4:0] code;
    } t_match;

    // Words are held left-justified, zero padded; table entries likewise.
    localparam logic [47:0] KW_TXT [21] = '{
        {"CLS", 24'd0}, {"ELSE", 16'd0}, "ELSEIF", "END IF", {"END", 24'd0},
        {"FOR", 24'd0}, {"GOTO", 16'd0}, {"GOSUB", 8'd0}, {"IF", 32'd0},
        {"INPUT", 8'd0}, {"LET", 24'd0}, {"NEXT", 16'd0}, {"PRINT", 8'd0},
        {"REM", 24'd0}, "RETURN", {"STEP", 16'd0}, {"THEN", 16'd0},
        {"TO", 32'd0}, {"WAIT", 16'd0}, {"WEND", 16'd0}, {"WHILE", 8'd0}
    };
    localparam logic [47:0] FN_TXT [3] = '{
        {"ABS", 24'd0}, {"RND", 24'd0}, {"TIME", 16'd0}
    };
    localparam logic [47:0] OPW_TXT [4] = '{
        {"MOD", 24'd0}, {"AND", 24'd0}, {"OR", 32'd0}, {"NOT", 24'd0}
    };
    localparam logic [4:0] OPW_CODE [4] = '{5'd4, 5'd13, 5'd14, 5'd15};

    function automatic t_item tok(input logic [3:0] kind, input logic [4:0] code);
        t_item it;
        it.kind  = kind;
        it.code  = code;
        it.ch    = 8'd0;
        it.cv    = 1'b0;
        it.first = 1'b1;
        it.last  = 1'b1;
        return it;
    endfunction

    function automatic t_item flush_item(input t_pend p);
        t_item it;
        case (p)
            PEND_END: it = tok(KIND_KW, KW_END);
            PEND_LT:  it = tok(KIND_OP, OP_LT);
            default:  it = tok(KIND_OP, OP_GT);
        endcase
        return it;
    endfunction

    // Matches a word of n characters (1..MAX) against the fixed tables.
    // Word characters are never zero, so zero padding settles the length.
    function automatic t_match word_lookup(input logic [47:0] w,
                                           input logic [WLEN_W-1:0] n);
        t_match     m;
        logic [47:0] masked;
        masked = '0;
        for (int i = 0; i < SHADOW_CHARS; i++) begin
            if (n > WLEN_W'(i)) begin
                masked[47-8*i -: 8] = w[47-8*i -: 8];
            end
        end
        m.wk   = WK_IDENT;
        m.code = CODE_NONE;
        if (n <= WLEN_W'(SHADOW_CHARS)) begin
            for (int i = 3; i >= 0; i--) begin
                if (masked == OPW_TXT[i]) begin
                    m.wk   = WK_OP;
                    m.code = OPW_CODE[i];
                end
            end
            for (int i = 2; i >= 0; i--) begin
                if (masked == FN_TXT[i]) begin
                    m.wk   = WK_FN;
                    m.code = 5'(i);
                end
            end
            for (int i = 20; i >= 0; i--) begin
                if (masked == KW_TXT[i]) begin
                    m.wk   = WK_KW;
                    m.code = 5'(i);
                end
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/bst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the word character buffer.
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bst_front.sv =====
// Front end: accepts source characters and classifies them into commands.
// Depends on bst_pkg.
module bst_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_ch,
    input  logic          i_eos,
    output logic          o_push,
    input  logic          i_q_ready,
    output bst_pkg::t_cmd o_cmd
);
    import bst_pkg::*;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        o_cmd.ch  = i_ch;
        o_cmd.eos = i_eos;
        o_cmd.opc = CODE_NONE;
        o_cmd.cls = CLS_OTHER;
        if ((i_ch >= "A" && i_ch <= "Z") || (i_ch >= "a" && i_ch <= "z")) begin
            o_cmd.cls = CLS_LETTER;
        end else if (i_ch >= "0" && i_ch <= "9") begin
            o_cmd.cls = CLS_DIGIT;
        end else begin
            case (i_ch)
                " ":   o_cmd.cls = CLS_SPACE;
                "\"":  o_cmd.cls = CLS_QUOTE;
                8'h0A: o_cmd.cls = CLS_NEWLINE;
                ";":   o_cmd.cls = CLS_SEMI;
                ",":   o_cmd.cls = CLS_COMMA;
                "(": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_LPAREN; end
                ")": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_RPAREN; end
                "*": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_MUL; end
                "/": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_DIV; end
                "+": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_ADD; end
                "-": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_SUB; end
                "<": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_LT; end
                ">": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_GT; end
                "=": begin o_cmd.cls = CLS_OP; o_cmd.opc = OP_EQ; end
                default: o_cmd.cls = CLS_OTHER;
            endcase
        end
    end
endmodule

// ===== rtl/bst_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on bst_pkg.
module bst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bst_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output bst_pkg::t_cmd o_cmd
);
    import bst_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [PW-1:0]        r_wp, r_rp;
    logic [PW:0]          r_cnt;

    assign o_ready = r_cnt != (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule

// ===== rtl/bst_back.sv =====
// Back end: scanner sequencer, word buffer and result item output stage.
// Depends on bst_pkg and bst_ram.
module bst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  bst_pkg::t_cmd  i_q_cmd,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output bst_pkg::t_item o_m_item,
    output logic           o_m_lor
);
    import bst_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    t_mode             r_mode, n_mode;
    t_pend             r_pend, n_pend;
    logic [WLEN_W-1:0] r_wlen, n_wlen;
    logic [WLEN_W-1:0] r_n, n_n;
    logic              r_lclosed, n_lclosed;
    logic [47:0]       r_shadow, n_shadow;
    t_wk               r_wk, n_wk;
    logic [4:0]        r_wcode, n_wcode;
    logic [ADDR_W-1:0] r_idx, n_idx;

    // Hold slot: the newest item waits here until it is known whether
    // another item of the same step follows.
    logic              r_hv;
    t_item             r_hold;
    logic              r_ov;
    t_item             r_out;
    logic              r_olor;

    logic              emit, go, can_emit, out_free;
    t_item             e_item;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_rdata;
    logic              alnum;
    t_match            m;

    assign out_free = !r_ov || i_m_ready;
    assign can_emit = !r_hv || out_free;
    assign go       = !emit || can_emit;
    assign alnum    = (r_cmd.cls == CLS_LETTER) || (r_cmd.cls == CLS_DIGIT);
    assign m        = word_lookup(r_shadow, r_wlen);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign ram_re   = (r_state == S_IRD);

    bst_ram #(.WIDTH(8), .DEPTH(MAX_WORD_CHARS)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cmd.ch),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_START;
            S_START: begin
                if (r_cmd.eos) begin
                    case (r_mode)
                        MODE_WORD: n_state = S_WF;
                        MODE_NUM:  n_state = S_NUM_END;
                        MODE_STR:  n_state = S_STR_END;
                        default:   n_state = S_EOS_FLUSH;
                    endcase
                end else begin
                    case (r_mode)
                        MODE_WORD: begin
                            if (!alnum) n_state = S_WF;
                            else if (r_wlen == WLEN_W'(MAX_WORD_CHARS))
                                n_state = S_OVF_FLUSH;
                            else n_state = S_DONE;
                        end
                        MODE_NUM: n_state = (r_cmd.cls == CLS_DIGIT) ? S_DONE : S_NUM_END;
                        MODE_STR: n_state = S_DONE;
                        default:  n_state = S_CHAR;
                    endcase
                end
            end
            S_WF:       n_state = (r_wlen == '0 || r_wlen > WLEN_W'(MAX_WORD_CHARS)) ?
                                  (r_cmd.eos ? S_EOS_FLUSH : S_CHAR) : S_WF_FLUSH;
            S_WF_FLUSH: n_state = S_WF_TOK;
            S_WF_TOK:   n_state = (r_wk == WK_IDENT) ? S_IRD :
                                  (r_cmd.eos ? S_EOS_FLUSH : S_CHAR);
            S_IRD:      n_state = S_IEM;
            S_IEM:      n_state = ({1'b0, r_idx} + 1'b1 == (ADDR_W+1)'(r_n)) ?
                                  (r_cmd.eos ? S_EOS_FLUSH : S_CHAR) : S_IRD;
            S_NUM_END:  n_state = r_cmd.eos ? S_EOS_FLUSH : S_CHAR;
            S_STR_END:  n_state = S_STR_ERR;
            S_STR_ERR:  n_state = S_EOS_FLUSH;
            S_CHAR: begin
                if (r_cmd.cls == CLS_LETTER || r_cmd.cls == CLS_SPACE) n_state = S_DONE;
                else if (r_cmd.cls == CLS_OP &&
                         ((r_cmd.opc == OP_EQ && r_pend == PEND_LT) ||
                          (r_cmd.opc == OP_EQ && r_pend == PEND_GT) ||
                          (r_cmd.opc == OP_GT && r_pend == PEND_LT)))
                    n_state = S_DONE;
                else n_state = S_CHAR_FLUSH;
            end
            S_CHAR_FLUSH: n_state = S_CHAR_TOK;
            S_CHAR_TOK:   n_state = S_DONE;
            S_OVF_FLUSH:  n_state = S_OVF_ERR;
            S_OVF_ERR:    n_state = S_DONE;
            S_EOS_FLUSH:  n_state = S_EOS_EOI;
            S_EOS_EOI:    n_state = S_DONE;
            S_DONE:       n_state = (!r_hv || out_free) ? S_IDLE : S_DONE;
            default:      n_state = S_IDLE;
        endcase
        if (!go) n_state = r_state;
    end

    // Emitted items and scanner state updates.
    always_comb begin
        emit      = 1'b0;
        e_item    = tok(KIND_IDENT, CODE_NONE);
        ram_we    = 1'b0;
        ram_waddr = r_wlen[ADDR_W-1:0];
        n_cmd     = r_cmd;
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_wlen    = r_wlen;
        n_n       = r_n;
        n_shadow  = r_shadow;
        n_wk      = r_wk;
        n_wcode   = r_wcode;
        n_idx     = r_idx;
        case (r_state)
            S_IDLE: if (i_q_valid) n_cmd = i_q_cmd;
            S_START: begin
                if (!r_cmd.eos && r_mode == MODE_WORD && alnum &&
                    r_wlen < WLEN_W'(MAX_WORD_CHARS)) begin
                    ram_we = 1'b1;
                    for (int i = 0; i < SHADOW_CHARS; i++) begin
                        if (r_wlen == WLEN_W'(i)) n_shadow[47-8*i -: 8] = r_cmd.ch;
                    end
                    n_wlen = r_wlen + 1'b1;
                end else if (!r_cmd.eos && r_mode == MODE_NUM &&
                             r_cmd.cls == CLS_DIGIT) begin
                    emit   = 1'b1;
                    e_item = '{KIND_NUMBER, CODE_NONE, r_cmd.ch, 1'b1, 1'b0, 1'b0};
                end else if (!r_cmd.eos && r_mode == MODE_STR) begin
                    emit = 1'b1;
                    if (r_cmd.cls == CLS_QUOTE) begin
                        e_item = '{KIND_STRING, CODE_NONE, 8'd0, 1'b0,
                                   r_wlen == '0, 1'b1};
                        n_mode = MODE_IDLE;
                        n_wlen = '0;
                    end else begin
                        e_item = '{KIND_STRING, CODE_NONE, r_cmd.ch, 1'b1,
                                   r_wlen == '0, 1'b0};
                        n_wlen = WLEN_W'(1);
                    end
                end
            end
            S_WF: begin
                n_n    = r_wlen;
                n_wlen = '0;
                n_mode = MODE_IDLE;
                n_idx  = '0;
                n_wcode = m.code;
                if (m.wk == WK_KW && m.code == KW_IF && r_pend == PEND_END)
                    n_wk = WK_MERGE;
                else if (m.wk == WK_KW && m.code == KW_END) n_wk = WK_END;
                else n_wk = m.wk;
            end
            S_WF_FLUSH: begin
                if (r_wk != WK_MERGE && r_pend != PEND_NONE) begin
                    emit   = 1'b1;
                    e_item = flush_item(r_pend);
                end
                n_pend = (r_wk == WK_END) ? PEND_END : PEND_NONE;
            end
            S_WF_TOK: begin
                case (r_wk)
                    WK_MERGE: begin emit = 1'b1; e_item = tok(KIND_KW, KW_END_IF); end
                    WK_KW:    begin emit = 1'b1; e_item = tok(KIND_KW, r_wcode); end
                    WK_FN:    begin emit = 1'b1; e_item = tok(KIND_FUNC, r_wcode); end
                    WK_OP:    begin emit = 1'b1; e_item = tok(KIND_OP, r_wcode); end
                    default:  emit = 1'b0;
                endcase
            end
            S_IEM: begin
                emit   = 1'b1;
                e_item = '{KIND_IDENT, CODE_NONE, ram_rdata, 1'b1, r_idx == '0,
                           {1'b0, r_idx} + 1'b1 == (ADDR_W+1)'(r_n)};
                n_idx  = r_idx + 1'b1;
            end
            S_NUM_END: begin
                emit   = 1'b1;
                e_item = '{KIND_NUMBER, CODE_NONE, 8'd0, 1'b0, 1'b0, 1'b1};
                n_mode = MODE_IDLE;
            end
            S_STR_END: begin
                emit   = 1'b1;
                e_item = '{KIND_STRING, CODE_NONE, 8'd0, 1'b0, r_wlen == '0, 1'b1};
            end
            S_STR_ERR: begin
                emit   = 1'b1;
                e_item = tok(KIND_ERROR, ERR_STRING);
            end
            S_CHAR: begin
                if (r_cmd.cls == CLS_LETTER) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    n_shadow  = {r_cmd.ch, 40'd0};
                    n_wlen    = WLEN_W'(1);
                    n_mode    = MODE_WORD;
                end else if (r_cmd.cls == CLS_OP) begin
                    if (r_cmd.opc == OP_EQ && r_pend == PEND_LT) begin
                        emit = 1'b1; e_item = tok(KIND_OP, OP_LE); n_pend = PEND_NONE;
                    end else if (r_cmd.opc == OP_EQ && r_pend == PEND_GT) begin
                        emit = 1'b1; e_item = tok(KIND_OP, OP_GE); n_pend = PEND_NONE;
                    end else if (r_cmd.opc == OP_GT && r_pend == PEND_LT) begin
                        emit = 1'b1; e_item = tok(KIND_OP, OP_NE); n_pend = PEND_NONE;
                    end
                end
            end
            S_CHAR_FLUSH, S_OVF_FLUSH, S_EOS_FLUSH: begin
                if (r_pend != PEND_NONE) begin
                    emit   = 1'b1;
                    e_item = flush_item(r_pend);
                end
                n_pend = PEND_NONE;
            end
            S_CHAR_TOK: begin
                case (r_cmd.cls)
                    CLS_OP: begin
                        if (r_cmd.opc == OP_LT) n_pend = PEND_LT;
                        else if (r_cmd.opc == OP_GT) n_pend = PEND_GT;
                        else begin emit = 1'b1; e_item = tok(KIND_OP, r_cmd.opc); end
                    end
                    CLS_DIGIT: begin
                        emit   = 1'b1;
                        e_item = '{KIND_NUMBER, CODE_NONE, r_cmd.ch, 1'b1, 1'b1, 1'b0};
                        n_mode = MODE_NUM;
                    end
                    CLS_QUOTE: begin
                        n_mode = MODE_STR;
                        n_wlen = '0;
                    end
                    CLS_NEWLINE: begin emit = 1'b1; e_item = tok(KIND_EOI, CODE_NONE); end
                    CLS_SEMI:    begin emit = 1'b1; e_item = tok(KIND_SEMI, CODE_NONE); end
                    CLS_COMMA:   begin emit = 1'b1; e_item = tok(KIND_COMMA, CODE_NONE); end
                    default:     begin emit = 1'b1; e_item = tok(KIND_ERROR, ERR_UNKNOWN); end
                endcase
            end
            S_OVF_ERR: begin
                emit   = 1'b1;
                e_item = tok(KIND_ERROR, ERR_LONG);
                n_wlen = WLEN_W'(MAX_WORD_CHARS + 1);
            end
            S_EOS_EOI: begin
                emit   = !r_lclosed;
                e_item = tok(KIND_EOI, CODE_NONE);
                n_mode = MODE_IDLE;
                n_wlen = '0;
                n_pend = PEND_NONE;
            end
            default: emit = 1'b0;
        endcase
        n_lclosed = r_lclosed;
        if (emit) n_lclosed = (e_item.kind == KIND_EOI);
        if (r_state == S_EOS_EOI) n_lclosed = 1'b0;
        if (!go) begin
            ram_we    = 1'b0;
            n_cmd     = r_cmd;
            n_mode    = r_mode;
            n_pend    = r_pend;
            n_wlen    = r_wlen;
            n_n       = r_n;
            n_shadow  = r_shadow;
            n_wk      = r_wk;
            n_wcode   = r_wcode;
            n_idx     = r_idx;
            n_lclosed = r_lclosed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_IDLE;
            r_pend    <= PEND_NONE;
            r_wlen    <= '0;
            r_lclosed <= 1'b0;
            r_hv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_wlen    <= n_wlen;
            r_lclosed <= n_lclosed;
            if (emit && go) begin
                r_hv <= 1'b1;
            end else if (r_state == S_DONE && r_hv && out_free) begin
                r_hv <= 1'b0;
            end
            if ((emit && go && r_hv) || (r_state == S_DONE && r_hv && out_free)) begin
                r_ov <= 1'b1;
            end else if (i_m_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_n      <= n_n;
        r_shadow <= n_shadow;
        r_wk     <= n_wk;
        r_wcode  <= n_wcode;
        r_idx    <= n_idx;
        if (emit && go) begin
            r_hold <= e_item;
            if (r_hv) begin
                r_out  <= r_hold;
                r_olor <= 1'b0;
            end
        end else if (r_state == S_DONE && r_hv && out_free) begin
            r_out  <= r_hold;
            r_olor <= 1'b1;
        end
    end

    assign o_m_valid = r_ov;
    assign o_m_item  = r_out;
    assign o_m_lor   = r_olor;
endmodule

// ===== rtl/basic_source_tokenizer_unit.sv =====
// Top level of the BASIC source tokenizer: one character in, tokens out.
// Identifier characters are read back from the word RAM, whose read is registered, and
// output stalls hold the back end sequencer.
// The back end handles one item at a time; a two-entry queue lets the
// front end keep accepting while the back end or the output is busy.
// Reset is synchronous, active low, and returns the scanner to idle between tokens.
module basic_source_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,   // end_of_source
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] text_char, [8] first_of_token,
                                          // [9] last_of_token, [15:10] zero
    output logic [9:0]  o_m_axis_tuser,   // [3:0] token_kind, [8:4] token_code,
                                          // [9] char_valid
    output logic        o_m_axis_tlast    // last_of_run
);
    import bst_pkg::*;

    logic  push, q_ready, q_valid, q_pop;
    t_cmd  f_cmd, q_cmd;
    t_item item;

    // The front end classifies each character and pushes it into the queue.
    bst_front u_front (
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_ch      (i_s_axis_tdata),
        .i_eos     (i_s_axis_tlast),
        .o_push    (push),
        .i_q_ready (q_ready),
        .o_cmd     (f_cmd)
    );

    bst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    // The back end runs the scanner and owns the output register.
    bst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_cmd   (q_cmd),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_item  (item),
        .o_m_lor   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, item.last, item.first, item.ch};
    assign o_m_axis_tuser = {item.cv, item.code, item.kind};
endmodule
